// ===== rtl/core/sliding_anagram_finder_assert.svh =====
// Assertion macros shared by the sliding anagram finder RTL.
`ifndef SLIDING_ANAGRAM_FINDER_ASSERT_SVH
`define SLIDING_ANAGRAM_FINDER_ASSERT_SVH

`ifndef SYNTHESIS

// condition holds at every edge out of reset
`define SAF_ASSERT_ALW(lbl, clk_s, rstn_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond)) \
    else $error("saf assertion failed");

// same-cycle implication
`define SAF_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("saf assertion failed");

// next-cycle implication
`define SAF_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("saf assertion failed");

`else

`define SAF_ASSERT_ALW(lbl, clk_s, rstn_s, cond)
`define SAF_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define SAF_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

// ===== rtl/core/saf_pkg.sv =====
// Shared constants and types for the sliding anagram finder.
package saf_pkg;

  localparam int MODE_W          = 2;
  localparam int BYTE_W          = 8;
  localparam int POS_W           = 32;
  localparam int MAX_PATTERN_DEF = 64;
  localparam int SYMBOL_BITS_DEF = 8;
  localparam int CNT_W_DEF       = $clog2(MAX_PATTERN_DEF + 2);

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR   = 2'd0,
    MODE_PATTERN = 2'd1,
    MODE_TEXT    = 2'd2,
    MODE_RESTART = 2'd3
  } mode_t;

endpackage

// ===== rtl/core/saf_stream_if.sv =====
// Valid/ready channel interfaces for the input items and the match results.
interface saf_in_if import saf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [BYTE_W-1:0] byte_value;

  modport source (output valid, output mode, output byte_value, input ready);
  modport sink   (input valid, input mode, input byte_value, output ready);
endinterface

interface saf_out_if import saf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             matched;
  logic [POS_W-1:0] window_start;

  modport source (output valid, output matched, output window_start, input ready);
  modport sink   (input valid, input matched, input window_start, output ready);
endinterface

// ===== rtl/core/saf_cnt_store.sv =====
// Per-symbol count memory with valid bits, two read ports and write forwarding.
module saf_cnt_store import saf_pkg::*; #(
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
  parameter int CNT_W       = CNT_W_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   rd_en,
  input  logic [SYMBOL_BITS-1:0] ra_sym,
  input  logic [SYMBOL_BITS-1:0] ra_old,
  input  logic                   wr_en,
  input  logic                   wr_clr,
  input  logic [SYMBOL_BITS-1:0] wr_addr,
  input  logic [CNT_W-1:0]       wr_data,
  output logic [CNT_W-1:0]       rd_sym,
  output logic [CNT_W-1:0]       rd_old
);

  localparam int NSYM = 1 << SYMBOL_BITS;

  logic [CNT_W-1:0]       mem [NSYM];
  logic [NSYM-1:0]        vld_r;
  logic [SYMBOL_BITS-1:0] ra [2];
  logic [1:0]             fwd_wr;
  logic [CNT_W-1:0]       q_r [2];
  logic [1:0]             ovr_en_r;
  logic [CNT_W-1:0]       ovr_val_r [2];

  assign ra[0] = ra_sym;
  assign ra[1] = ra_old;

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      fwd_wr[p] = wr_en && (wr_addr == ra[p]);
    end
  end

  // read is old-data; a write or clear in the same cycle is forwarded
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      for (int p = 0; p < 2; p++) begin
        q_r[p]       <= mem[ra[p]];
        ovr_en_r[p]  <= fwd_wr[p] || wr_clr || !vld_r[ra[p]];
        ovr_val_r[p] <= fwd_wr[p] ? wr_data : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_clr) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_sym = ovr_en_r[0] ? ovr_val_r[0] : q_r[0];
  assign rd_old = ovr_en_r[1] ? ovr_val_r[1] : q_r[1];

endmodule

// ===== rtl/core/sliding_anagram_finder.sv =====
// Sliding anagram finder top level: pattern load, text streaming, match reporting.
// Input channel in_chan carries mode and byte_value; mode selects clear all,
// pattern byte, text byte or restart text. Output channel out_chan carries one
// result (matched, window_start) per text byte once the window holds as many
// text bytes as the pattern; other transactions produce no result.
// Throughput is one input transaction per cycle unless the receiver stalls. The
// work runs in three steps: ring read of the oldest byte, count memory reads, then
// count and tally update with forwarding from the update step back into the reads.
// A result passes the first-step and second-step registers to the output register.
// When the receiver stalls, the result holds in the output register; input is
// still taken until the two internal steps are also occupied.
// Reset clears the pattern, window counts, tally and position at once through
// per-symbol valid bits; the block accepts input in the first cycle after reset.
`include "sliding_anagram_finder_assert.svh"

module sliding_anagram_finder import saf_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  saf_in_if.sink   in_chan,
  saf_out_if.source out_chan
);

  localparam int CNT_W  = $clog2(MAX_PATTERN + 2);
  localparam int RING_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [CNT_W-1:0] PAT_MAX = CNT_W'(MAX_PATTERN);

  typedef struct packed {
    logic                   cnt_op;
    logic                   full;
    logic                   emit;
    logic                   pat_wr;
    logic                   clr_win;
    logic                   clr_pat;
    logic [SYMBOL_BITS-1:0] sym;
    logic [SYMBOL_BITS-1:0] old;
    logic [CNT_W-1:0]       plen;
    logic [POS_W-1:0]       pos;
  } s2_t;

  // handshake and stage control
  logic in_fire, in_ready, s1_commit, s2_fire, s2_load_ok, en_out;
  logic s1_v_r, s2_v_r, out_v_r;

  // first step
  mode_t                         s1_mode_r;
  logic [SYMBOL_BITS-1:0]        s1_sym_r;
  logic [SYMBOL_BITS+BYTE_W-1:0] in_sym_ext;
  logic [SYMBOL_BITS-1:0]        in_sym;

  logic [CNT_W-1:0]  plen_r, plen_a, plen_nxt;
  logic [CNT_W-1:0]  fill_r, fill_a, fill_nxt;
  logic [RING_W-1:0] head_r, head_a, head_nxt;
  logic [POS_W-1:0]  pos_r, pos_a, pos_nxt;
  logic [CNT_W-1:0]  head_ext, head_inc;
  logic              text_live, win_full, emit, pat_wr, clr_win, clr_pat;

  logic [SYMBOL_BITS-1:0] ring_mem [MAX_PATTERN];
  logic [SYMBOL_BITS-1:0] ring_q_r, ring_fwd_sym_r, old_sym;
  logic                   ring_we, ring_fwd, ring_fwd_r;

  // second step
  s2_t              s2_r, s2_nxt;
  logic [CNT_W-1:0] in_s, in_o, out_s, out_o, pc_s, pc_o;
  logic [CNT_W-1:0] wc_s, wc_o, tally_r, tally1, tally2;
  logic             enter_hit, leave_hit;
  logic             in_we, out_we, pat_we, win_clr, pat_clr;

  logic             matched_r;
  logic [POS_W-1:0] start_r;

  // ---------------------------------------------------------------- handshake
  assign en_out     = !out_v_r || out_chan.ready;
  assign s2_fire    = s2_v_r && (!s2_r.emit || en_out);
  assign s2_load_ok = !s2_v_r || s2_fire;
  assign s1_commit  = s1_v_r && s2_load_ok;
  assign in_ready   = rst_n && (!s1_v_r || s1_commit);
  assign in_fire    = in_chan.valid && in_ready;

  assign in_chan.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_v_r <= 1'b1;
      end else if (s1_commit) begin
        s1_v_r <= 1'b0;
      end
      if (s1_commit) begin
        s2_v_r <= 1'b1;
      end else if (s2_fire) begin
        s2_v_r <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------- first step
  assign in_sym_ext = {{SYMBOL_BITS{1'b0}}, in_chan.byte_value};
  assign in_sym     = in_sym_ext[SYMBOL_BITS-1:0];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r <= mode_t'(in_chan.mode);
      s1_sym_r  <= in_sym;
    end
  end

  assign text_live = (s1_mode_r == MODE_TEXT) && (plen_r != '0);
  assign win_full  = fill_r >= plen_r;
  assign head_ext  = CNT_W'(head_r);
  assign head_inc  = head_ext + 1'b1;

  always_comb begin
    plen_a  = plen_r;
    fill_a  = fill_r;
    head_a  = head_r;
    pos_a   = pos_r;
    pat_wr  = 1'b0;
    clr_win = 1'b0;
    clr_pat = 1'b0;
    case (s1_mode_r)
      MODE_CLEAR: begin
        plen_a  = '0;
        fill_a  = '0;
        head_a  = '0;
        pos_a   = '0;
        clr_win = 1'b1;
        clr_pat = 1'b1;
      end
      MODE_PATTERN: begin
        // bytes beyond capacity are dropped, the text restarts anyway
        if (plen_r < PAT_MAX) begin
          plen_a = plen_r + 1'b1;
          pat_wr = 1'b1;
        end
        fill_a  = '0;
        head_a  = '0;
        pos_a   = '0;
        clr_win = 1'b1;
      end
      MODE_RESTART: begin
        fill_a  = '0;
        head_a  = '0;
        pos_a   = '0;
        clr_win = 1'b1;
      end
      MODE_TEXT: begin
        if (text_live) begin
          if (win_full) begin
            if (pos_r != POS_MAX) begin
              pos_a = pos_r + 1'b1;
            end
          end else begin
            fill_a = fill_r + 1'b1;
          end
          head_a = (head_inc >= plen_r) ? '0 : head_inc[RING_W-1:0];
        end
      end
      default: begin
        plen_a = plen_r;
      end
    endcase
  end

  assign emit = text_live && (fill_a >= plen_r);

  assign plen_nxt = s1_commit ? plen_a : plen_r;
  assign fill_nxt = s1_commit ? fill_a : fill_r;
  assign head_nxt = s1_commit ? head_a : head_r;
  assign pos_nxt  = s1_commit ? pos_a  : pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r <= '0;
      fill_r <= '0;
      head_r <= '0;
      pos_r  <= '0;
    end else begin
      plen_r <= plen_nxt;
      fill_r <= fill_nxt;
      head_r <= head_nxt;
      pos_r  <= pos_nxt;
    end
  end

  // oldest byte for the next transaction is fetched at accept time
  assign ring_we  = s1_commit && text_live;
  assign ring_fwd = ring_we && (head_r == head_nxt);

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[head_r] <= s1_sym_r;
    end
    if (in_fire) begin
      ring_q_r       <= ring_mem[head_nxt];
      ring_fwd_r     <= ring_fwd;
      ring_fwd_sym_r <= s1_sym_r;
    end
  end

  assign old_sym = ring_fwd_r ? ring_fwd_sym_r : ring_q_r;

  always_comb begin
    s2_nxt.cnt_op  = text_live;
    s2_nxt.full    = win_full;
    s2_nxt.emit    = emit;
    s2_nxt.pat_wr  = pat_wr;
    s2_nxt.clr_win = clr_win;
    s2_nxt.clr_pat = clr_pat;
    s2_nxt.sym     = s1_sym_r;
    s2_nxt.old     = old_sym;
    s2_nxt.plen    = plen_r;
    s2_nxt.pos     = pos_a;
  end

  always_ff @(posedge clk) begin
    if (s1_commit) begin
      s2_r <= s2_nxt;
    end
  end

  // ------------------------------------------------------------ count stores
  // window count is entered minus left, both kept modulo 2^CNT_W
  saf_cnt_store #(.SYMBOL_BITS(SYMBOL_BITS), .CNT_W(CNT_W)) u_in_cnt (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (s1_commit),
    .ra_sym  (s1_sym_r),
    .ra_old  (old_sym),
    .wr_en   (in_we),
    .wr_clr  (win_clr),
    .wr_addr (s2_r.sym),
    .wr_data (in_s + 1'b1),
    .rd_sym  (in_s),
    .rd_old  (in_o)
  );

  saf_cnt_store #(.SYMBOL_BITS(SYMBOL_BITS), .CNT_W(CNT_W)) u_out_cnt (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (s1_commit),
    .ra_sym  (s1_sym_r),
    .ra_old  (old_sym),
    .wr_en   (out_we),
    .wr_clr  (win_clr),
    .wr_addr (s2_r.old),
    .wr_data (out_o + 1'b1),
    .rd_sym  (out_s),
    .rd_old  (out_o)
  );

  saf_cnt_store #(.SYMBOL_BITS(SYMBOL_BITS), .CNT_W(CNT_W)) u_pat_cnt (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (s1_commit),
    .ra_sym  (s1_sym_r),
    .ra_old  (old_sym),
    .wr_en   (pat_we),
    .wr_clr  (pat_clr),
    .wr_addr (s2_r.sym),
    .wr_data (pc_s + 1'b1),
    .rd_sym  (pc_s),
    .rd_old  (pc_o)
  );

  // ------------------------------------------------------------ second step
  assign wc_s      = in_s - out_s;
  assign enter_hit = wc_s < pc_s;
  assign tally1    = tally_r + CNT_W'(enter_hit);
  assign wc_o      = (s2_r.old == s2_r.sym) ? wc_s + 1'b1 : in_o - out_o;
  assign leave_hit = s2_r.full && (wc_o <= pc_o) && (tally1 != '0);
  assign tally2    = tally1 - CNT_W'(leave_hit);

  assign in_we   = s2_fire && s2_r.cnt_op;
  assign out_we  = s2_fire && s2_r.cnt_op && s2_r.full && (wc_o != '0);
  assign pat_we  = s2_fire && s2_r.pat_wr;
  assign win_clr = s2_fire && s2_r.clr_win;
  assign pat_clr = s2_fire && s2_r.clr_pat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r <= '0;
    end else if (s2_fire) begin
      if (s2_r.clr_win) begin
        tally_r <= '0;
      end else if (s2_r.cnt_op) begin
        tally_r <= tally2;
      end
    end
  end

  // ---------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s2_fire && s2_r.emit) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && s2_r.emit) begin
      matched_r <= (tally2 == s2_r.plen);
      start_r   <= s2_r.pos;
    end
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.matched      = matched_r;
  assign out_chan.window_start = start_r;

  // --------------------------------------------------------------- assertions
  `SAF_ASSERT_ALW(a_fill_le_plen, clk, rst_n, fill_r <= plen_r)
  `SAF_ASSERT_IMP(a_head_in_window, clk, rst_n, plen_r != '0, head_ext < plen_r)
  `SAF_ASSERT_IMP(a_tally_le_plen, clk, rst_n, s2_v_r, tally_r <= s2_r.plen)

endmodule
